/* hdl/fcvbs_pkg.sv */
// package for the five-copy voting byte store
// request and response payload types, opcodes, status codes and defaults
`default_nettype none
package fcvbs_pkg;

  localparam int COPIES_DEF      = 5;
  localparam int STORE_CELLS_DEF = 256;

  localparam logic [7:0] CELL_ERASED = 8'hFF;

  typedef enum logic [1:0] {
    OP_VREAD  = 2'd0,
    OP_WRITE  = 2'd1,
    OP_RAW_WR = 2'd2,
    OP_RAW_RD = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_REPAIRED    = 2'd1,
    ST_NO_MAJORITY = 2'd2,
    ST_RANGE       = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] address;
    logic [7:0] write_data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] status;
  } rsp_t;

endpackage
`default_nettype wire

/* hdl/five_copy_voting_byte_store.sv */
// five-copy voting byte store, top level: sequencer, cell memory and vote logic
// depends on fcvbs_pkg
//
// Each logical byte lives in COPIES consecutive cells of a single-port cell memory
// (one access per cycle, registered read data). After reset the block first walks
// the memory writing the erased value 0xFF, one cell per cycle, so no request is
// taken until every cell has been cleared. Requests use the single memory port as
// follows: a raw cell read reads the cell; a raw cell write writes the cell and reads
// it back; a redundant write writes each copy in turn and reads back the first copy;
// a voted read reads each copy in turn and votes, then writes the majority value back
// to every copy when a copy has to be repaired; an address out of range is answered
// with a range status and no memory access. One request is handled at a time; a
// finished response waits in an output register while the next request is taken.
`default_nettype none
module five_copy_voting_byte_store
  import fcvbs_pkg::*;
#(
  parameter int COPIES      = COPIES_DEF,
  parameter int STORE_CELLS = STORE_CELLS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  localparam int CELL_W      = $clog2(STORE_CELLS);
  localparam int CNT_W       = $clog2(COPIES);
  localparam int VCNT_W      = $clog2(COPIES + 1);
  localparam int LOG_ENTRIES = STORE_CELLS / COPIES;
  localparam int MAJORITY    = COPIES / 2 + 1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RAW_WR,
    S_FILL,
    S_READ,
    S_READ_LAST,
    S_VOTE,
    S_PEEK,
    S_PEEK_DATA,
    S_DONE
  } state_t;

  state_t              state;
  logic [CELL_W-1:0]   clr_idx;
  logic [CELL_W-1:0]   base;
  logic [CELL_W-1:0]   peek_addr;
  logic [CNT_W-1:0]    cnt;
  logic                cap;
  logic [CNT_W-1:0]    cap_idx;
  logic [1:0]          op;
  logic [7:0]          fill_val;
  rsp_t                res;
  logic [7:0]          copy_q [COPIES];

  logic [7:0]          mem [STORE_CELLS];
  logic [7:0]          rd_data;
  logic [CELL_W-1:0]   mem_addr;
  logic                mem_we;
  logic [7:0]          mem_wdata;

  logic [VCNT_W-1:0]   match_cnt [COPIES];
  logic                all_agree;
  logic                maj_found;
  logic [CNT_W-1:0]    maj_sel;

  logic                log_range_bad;
  logic                raw_range_bad;
  logic                last_copy;

  assign req_stall     = (state != S_IDLE);
  assign log_range_bad = (32'(req.address) >= LOG_ENTRIES);
  assign raw_range_bad = (32'(req.address) >= STORE_CELLS);
  assign last_copy     = (cnt == CNT_W'(COPIES - 1));

  // memory port mux
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = peek_addr;
    mem_wdata = (state == S_CLEAR) ? CELL_ERASED : fill_val;
    case (state)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_idx;
      end
      S_RAW_WR: begin
        mem_we   = 1'b1;
      end
      S_FILL: begin
        mem_we   = 1'b1;
        mem_addr = CELL_W'(base + CELL_W'(cnt));
      end
      S_READ: begin
        mem_addr = CELL_W'(base + CELL_W'(cnt));
      end
      default: begin
        mem_addr = peek_addr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data <= mem[mem_addr];
  end

  // match counts and first copy with a majority
  always_comb begin
    logic found;
    found   = 1'b0;
    maj_sel = '0;
    for (int i = 0; i < COPIES; i++) begin
      match_cnt[i] = '0;
      for (int j = 0; j < COPIES; j++) begin
        if (copy_q[i] == copy_q[j]) begin
          match_cnt[i] = VCNT_W'(match_cnt[i] + VCNT_W'(1));
        end
      end
    end
    for (int i = 0; i < COPIES; i++) begin
      if (!found && (match_cnt[i] >= VCNT_W'(MAJORITY))) begin
        found   = 1'b1;
        maj_sel = CNT_W'(i);
      end
    end
    maj_found = found;
    all_agree = (match_cnt[0] == VCNT_W'(COPIES));
  end

  always_ff @(posedge clk) begin
    if (cap) begin
      copy_q[cap_idx] <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      cap       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      cap <= (state == S_READ);
      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= CELL_W'(clr_idx + CELL_W'(1));
          if (clr_idx == CELL_W'(STORE_CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            op        <= req.opcode;
            fill_val  <= req.write_data;
            base      <= CELL_W'(32'(req.address) * COPIES);
            peek_addr <= CELL_W'(req.address);
            cnt       <= '0;
            res.read_data <= '0;
            res.status    <= ST_RANGE;
            case (req.opcode)
              OP_RAW_WR: state <= raw_range_bad ? S_DONE : S_RAW_WR;
              OP_RAW_RD: state <= raw_range_bad ? S_DONE : S_PEEK;
              OP_WRITE:  state <= log_range_bad ? S_DONE : S_FILL;
              default:   state <= log_range_bad ? S_DONE : S_READ;
            endcase
          end
        end
        S_RAW_WR: begin
          state <= S_PEEK;
        end
        S_FILL: begin
          cnt <= CNT_W'(cnt + CNT_W'(1));
          if (last_copy) begin
            peek_addr <= base;
            state     <= (op == OP_WRITE) ? S_PEEK : S_DONE;
          end
        end
        S_READ: begin
          cap_idx <= cnt;
          cnt     <= CNT_W'(cnt + CNT_W'(1));
          if (last_copy) begin
            state <= S_READ_LAST;
          end
        end
        S_READ_LAST: begin
          state <= S_VOTE;
        end
        S_VOTE: begin
          cnt <= '0;
          if (all_agree) begin
            res.read_data <= copy_q[0];
            res.status    <= ST_OK;
            state         <= S_DONE;
          end else if (maj_found) begin
            res.read_data <= copy_q[maj_sel];
            res.status    <= ST_REPAIRED;
            fill_val      <= copy_q[maj_sel];
            state         <= S_FILL;
          end else begin
            res.read_data <= '0;
            res.status    <= ST_NO_MAJORITY;
            state         <= S_DONE;
          end
        end
        S_PEEK: begin
          state <= S_PEEK_DATA;
        end
        S_PEEK_DATA: begin
          res.status <= ST_OK;
          if (op == OP_WRITE) begin
            res.read_data <= (rd_data == fill_val) ? rd_data : 8'd0;
          end else begin
            res.read_data <= rd_data;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
